/* src/lspd_pkg.sv */
// shared constants, types and tables of the scan packet decoder
`timescale 1ns / 1ps
package lspd_pkg;
   localparam int CordicSteps = 16;
   localparam int StepW = $clog2(CordicSteps + 1);
   localparam logic [7:0] SyncFirst = 8'hAA;
   localparam logic [7:0] SyncSecond = 8'h55;
   localparam logic signed [17:0] FullTurn = 18'sd23040;
   localparam int CW = 48;
   // radians at 2^30 to 1/64 degree: z * CorrScale / (6283 * 2^30)
   localparam logic [24:0] CorrScale = 25'd23040000;
   // ceil(2^39 / 6283), exact floor division by 6283 for 26-bit operands
   localparam logic [26:0] CorrRecip = 27'd87498936;

   // datapath commands from the controller
   typedef struct packed {
      logic clr_residual;
      logic hold_low;
      logic header_word;
      logic [1:0] header_sel;
      logic make_span;
      logic sample_word;
      logic cordic_load;
      logic cordic_step;
      logic div_load;
      logic div_step;
      logic finish;
      logic send;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic sample_last;
      logic out_busy;
   } stat_type;

   function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
      logic signed [31:0] v;
      begin
         case (i)
            5'd0: v = 32'sd843314857;
            5'd1: v = 32'sd497837829;
            5'd2: v = 32'sd263043837;
            5'd3: v = 32'sd133525159;
            5'd4: v = 32'sd67021687;
            5'd5: v = 32'sd33543516;
            5'd6: v = 32'sd16775851;
            5'd7: v = 32'sd8388437;
            5'd8: v = 32'sd4194283;
            5'd9: v = 32'sd2097149;
            5'd10: v = 32'sd1048576;
            5'd11: v = 32'sd524288;
            5'd12: v = 32'sd262144;
            5'd13: v = 32'sd131072;
            5'd14: v = 32'sd65536;
            5'd15: v = 32'sd32768;
            5'd16: v = 32'sd16384;
            5'd17: v = 32'sd8192;
            5'd18: v = 32'sd4096;
            5'd19: v = 32'sd2048;
            5'd20: v = 32'sd1024;
            5'd21: v = 32'sd512;
            5'd22: v = 32'sd256;
            5'd23: v = 32'sd128;
            default: v = 32'sd0;
         endcase
         return v;
      end
   endfunction
endpackage

/* src/lspd_datapath.sv */
// header registers, cordic, step divider and output register
`timescale 1ns / 1ps
module lspd_datapath (
   input  logic clock,
   input  logic reset,
   input  logic [7:0] req_rx_byte,
   input  lspd_pkg::cmd_type cmd,
   input  logic [lspd_pkg::StepW-1:0] step_idx,
   output lspd_pkg::stat_type stat,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic [15:0] rsp_distance,
   output logic [15:0] rsp_angle,
   output logic [7:0] rsp_sample_index,
   output logic rsp_last_sample,
   output logic [15:0] rsp_check_residual
);
   import lspd_pkg::*;

   logic [7:0] low_ff, count_ff, cur_ff;
   logic [14:0] first_ff, last_ff;
   logic [15:0] res_ff, dist_ff;
   logic signed [15:0] span_ff;
   logic [15:0] word;
   logic signed [CW-1:0] x_ff, y_ff, xs, ys;
   logic signed [31:0] z_ff;
   logic [4:0] si;
   // divider: dividend magnitude, quotient, remainder
   logic [23:0] num_ff, q_ff;
   logic [8:0] rem_ff;
   logic neg_ff;
   logic [8:0] rtry;
   logic [7:0] den;
   // angle scaling: magnitude, scaled and reciprocal products
   logic [30:0] zmag;
   logic [55:0] zscaled;
   logic [25:0] t_ff;
   logic [52:0] tprod;
   logic [13:0] cm_ff;
   logic signed [31:0] corr;
   logic signed [25:0] stepterm;
   logic signed [31:0] sum;
   logic [23:0] prodmag;
   logic signed [23:0] prod;
   logic v_ff;
   logic [15:0] od_ff, oa_ff, or_ff;
   logic [7:0] oi_ff;
   logic ol_ff;

   assign word = {req_rx_byte, low_ff};
   assign si = 5'(step_idx);
   assign xs = x_ff >>> si;
   assign ys = y_ff >>> si;
   assign den = count_ff - 8'd1;
   assign rtry = {rem_ff[7:0], num_ff[23]};
   assign prod = 24'(span_ff) * $signed({16'd0, cur_ff});
   assign prodmag = prod[23] ? 24'(-prod) : 24'(prod);
   // correction truncated toward zero: scale the magnitude, restore the sign
   assign zmag = z_ff[31] ? 31'(-z_ff) : 31'(z_ff);
   assign zscaled = {25'd0, zmag} * {31'd0, CorrScale};
   assign tprod = {27'd0, t_ff} * {26'd0, CorrRecip};
   assign corr = z_ff[31] ? -$signed({18'd0, cm_ff}) : $signed({18'd0, cm_ff});
   // floor for negative operands: negate and subtract one if inexact
   assign stepterm = (count_ff <= 8'd1) ? 26'sd0 :
      neg_ff ? -$signed({2'b0, q_ff}) - ((rem_ff != 9'd0) ? 26'sd1 : 26'sd0)
             : $signed({2'b0, q_ff});
   assign sum = 32'($signed({17'd0, first_ff})) + corr + 32'(stepterm);

   assign stat.count_zero = (count_ff == 8'd0);
   assign stat.sample_last = (32'(cur_ff) + 1 >= 32'(count_ff));
   assign stat.out_busy = v_ff && rsp_stall;

   // header and sample registers
   always_ff @(posedge clock) begin
      if (cmd.hold_low) low_ff <= req_rx_byte;
      if (cmd.clr_residual) res_ff <= 16'd0;
      else if (cmd.header_word || cmd.sample_word) res_ff <= res_ff ^ word;
      if (cmd.header_word) begin
         case (cmd.header_sel)
            2'd0: count_ff <= req_rx_byte;
            2'd1: first_ff <= word[15:1];
            2'd2: last_ff <= word[15:1];
            default: ;
         endcase
      end
      if (cmd.make_span) begin
         cur_ff <= 8'd0;
         span_ff <= (first_ff > last_ff) ?
            16'($signed({1'b0, last_ff}) + 17'sd23040 - $signed({1'b0, first_ff})) :
            16'($signed({1'b0, last_ff}) - $signed({1'b0, first_ff}));
      end
      if (cmd.sample_word) dist_ff <= word;
      if (cmd.finish) cur_ff <= cur_ff + 8'd1;
      if (cmd.cordic_load) begin
         x_ff <= CW'(64'sd15530 * $signed({48'd0, dist_ff}) * 64'sd65536);
         y_ff <= CW'(64'sd218 * (64'sd6212 - 64'sd10 * $signed({48'd0, dist_ff}))
                 * 64'sd65536);
         z_ff <= 32'sd0;
      end else if (cmd.cordic_step) begin
         if (!y_ff[CW-1]) begin
            x_ff <= x_ff + ys; y_ff <= y_ff - xs; z_ff <= z_ff + atan_entry(si);
         end else begin
            x_ff <= x_ff - ys; y_ff <= y_ff + xs; z_ff <= z_ff - atan_entry(si);
         end
      end
      // restoring divide, one quotient bit per cycle
      if (cmd.div_load) begin
         num_ff <= prodmag; neg_ff <= prod[23]; rem_ff <= 9'd0; q_ff <= 24'd0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[22:0], 1'b0};
         if (rtry >= {1'b0, den}) begin
            rem_ff <= rtry - {1'b0, den}; q_ff <= {q_ff[22:0], 1'b1};
         end else begin
            rem_ff <= rtry; q_ff <= {q_ff[22:0], 1'b0};
         end
      end
      // angle scaling settles during the divider steps: t_ff first, then cm_ff from it
      if (cmd.div_step) begin
         t_ff <= zscaled[55:30];
         cm_ff <= tprod[52:39];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (cmd.send) v_ff <= 1'b1;
      else if (!rsp_stall) v_ff <= 1'b0;
      if (cmd.send) begin
         od_ff <= dist_ff;
         oa_ff <= (dist_ff == 16'd0) ? 16'd0 :
            (sum < 0) ? 16'(sum + 32'sd23040) :
            (sum > 32'sd23040) ? 16'(sum - 32'sd23040) : 16'(sum);
         oi_ff <= cur_ff;
         ol_ff <= stat.sample_last;
         or_ff <= res_ff;
      end
   end

   assign rsp_valid = v_ff;
   assign rsp_distance = od_ff;
   assign rsp_angle = oa_ff;
   assign rsp_sample_index = oi_ff;
   assign rsp_last_sample = ol_ff;
   assign rsp_check_residual = or_ff;
endmodule

/* src/lspd_control.sv */
// parse and sample sequencing state machine
`timescale 1ns / 1ps
module lspd_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_rx_byte,
   input  lspd_pkg::stat_type stat,
   output lspd_pkg::cmd_type cmd,
   output logic [lspd_pkg::StepW-1:0] step_idx
);
   import lspd_pkg::*;

   localparam logic [2:0] StHunt = 3'd0, StSync2 = 3'd1, StHeader = 3'd2,
      StData = 3'd3, StCordic = 3'd4, StDiv = 3'd5, StSend = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [4:0] div_ff, div_in;
   logic acc;

   assign req_stall = (state_ff == StCordic) || (state_ff == StDiv) ||
                      (state_ff == StSend);
   assign acc = req_valid && !req_stall;
   assign step_idx = step_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; step_in = step_ff; div_in = div_ff;
      cmd = '0;
      case (state_ff)
         StHunt: if (acc && req_rx_byte == SyncFirst) state_in = StSync2;
         StSync2: if (acc) begin
            if (req_rx_byte == SyncSecond) begin
               state_in = StHeader; cnt_in = 4'd0; cmd.clr_residual = 1'b1;
            end else state_in = StHunt;
         end
         StHeader: if (acc) begin
            if (!cnt_ff[0]) begin
               cmd.hold_low = 1'b1; cnt_in = cnt_ff + 4'd1;
            end else begin
               cmd.header_word = 1'b1;
               cmd.header_sel = cnt_ff[2:1];
               if (cnt_ff >= 4'd7) begin
                  cmd.make_span = 1'b1; cnt_in = 4'd0;
                  // count was written only at header word 0, so it is stable this edge
                  state_in = stat.count_zero ? StHunt : StData;
               end else cnt_in = cnt_ff + 4'd1;
            end
         end
         StData: if (acc) begin
            if (cnt_ff == 4'd0) begin
               cmd.hold_low = 1'b1; cnt_in = 4'd1;
            end else begin
               cmd.sample_word = 1'b1; cnt_in = 4'd0; state_in = StCordic;
               step_in = '0;
            end
         end
         StCordic: begin
            if (step_ff == '0) cmd.cordic_load = 1'b1;
            else cmd.cordic_step = 1'b1;
            if (step_ff == StepW'(CordicSteps)) begin
               cmd.div_load = 1'b1; state_in = StDiv; div_in = 5'd0;
            end else step_in = step_ff + 1'b1;
         end
         StDiv: begin
            cmd.div_step = 1'b1; div_in = div_ff + 5'd1;
            if (div_ff == 5'd23) state_in = StSend;
         end
         StSend: if (!stat.out_busy) begin
            cmd.send = 1'b1; cmd.finish = 1'b1;
            state_in = stat.sample_last ? StHunt : StData;
         end
         default: state_in = StHunt;
      endcase
   end

   // cordic step index lags load by one: step k applies shift k-1
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StHunt; cnt_ff <= 4'd0; step_ff <= '0; div_ff <= 5'd0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; step_ff <= step_in; div_ff <= div_in;
      end
   end
endmodule

/* src/lidar_scan_packet_decoder.sv */
// top level of the lidar scan packet decoder
// channel | dir | ports
// req     | in  | req_valid, req_stall, req_rx_byte
// rsp     | out | rsp_valid, rsp_stall, rsp_distance, rsp_angle, rsp_sample_index,
//         |     | rsp_last_sample, rsp_check_residual
// sync and header bytes are never stalled; after a sample's second byte the input
// stalls for the cordic load and its 16 steps, the divider's 24 quotient bits
// and the send state; the word is valid the cycle after the send
// reset is synchronous and returns the parser to hunting for sync
// a stalled result holds the parser in the send cycle before the next word is sent
`timescale 1ns / 1ps
module lidar_scan_packet_decoder (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [15:0] rsp_distance,
   output logic [15:0] rsp_angle,
   output logic [7:0] rsp_sample_index,
   output logic rsp_last_sample,
   output logic [15:0] rsp_check_residual
);
   import lspd_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic [StepW-1:0] step_idx;
   logic [StepW-1:0] shift_idx;

   assign shift_idx = (step_idx == '0) ? '0 : step_idx - 1'b1;

   lspd_control u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_rx_byte(req_rx_byte), .stat(stat), .cmd(cmd), .step_idx(step_idx));

   lspd_datapath u_dp (
      .clock(clock), .reset(reset), .req_rx_byte(req_rx_byte), .cmd(cmd),
      .step_idx(shift_idx), .stat(stat), .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance), .rsp_angle(rsp_angle),
      .rsp_sample_index(rsp_sample_index), .rsp_last_sample(rsp_last_sample),
      .rsp_check_residual(rsp_check_residual));
endmodule

/* tb/tb_top.sv */
// self-checking testbench for the lidar scan packet decoder
`timescale 1ns / 1ps
module tb_top;
   import lspd_pkg::*;

   // one expected result word
   typedef struct {
      logic [15:0] distance;
      logic [15:0] angle;
      logic [7:0]  sample_index;
      logic        last_sample;
      logic [15:0] check_residual;
   } sample_type;

   typedef enum logic [1:0] {
      HUNT = 2'd0,
      SYNC2 = 2'd1,
      HEADER = 2'd2,
      DATA = 2'd3
   } phase_type;

   int err_count = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      begin
         $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
         err_count++;
      end
   endtask

   // decoder prediction and queue of pending samples
   class sample_board;
      phase_type phase = HUNT;
      logic [3:0]  byte_cnt = 0;
      logic [7:0]  count = 0;
      logic [15:0] first_ang = 0;
      logic [15:0] last_ang = 0;
      logic [15:0] resid = 0;
      logic [7:0]  cur = 0;
      logic [7:0]  low_hold = 0;
      longint      span = 0;
      sample_type  pending[$];
      int          matched = 0;

      static function longint shr_floor(longint v, int s);
         return v >>> s;
      endfunction

      static function longint tilt(longint d);
         longint x, y, z, xs, ys;
         begin
            x = 64'sd15530 * d * 65536;
            y = 64'sd218 * (64'sd6212 - 10 * d) * 65536;
            z = 0;
            for (int i = 0; i < CordicSteps && i < 24; i++) begin
               xs = shr_floor(x, i);
               ys = shr_floor(y, i);
               if (y >= 0) begin
                  x += ys; y -= xs; z += longint'(atan_entry(i[4:0]));
               end else begin
                  x -= ys; y += xs; z -= longint'(atan_entry(i[4:0]));
               end
            end
            return (z * 115200000) / (64'sd31415 * (64'sd1 << 30));
         end
      endfunction

      function logic [15:0] angle_of(longint d, longint idx);
         longint sum, stp, n, q;
         begin
            if (d == 0) return 16'd0;
            stp = 0;
            if (count > 1) begin
               n = span * idx;
               q = n / (longint'(count) - 1);
               if ((n % (longint'(count) - 1)) != 0 && n < 0) q -= 1;
               stp = q;
            end
            sum = longint'(first_ang) + tilt(d) + stp;
            if (sum < 0) sum += 23040;
            else if (sum > 23040) sum -= 23040;
            return sum[15:0];
         end
      endfunction

      function void note_byte(logic [7:0] b);
         logic [15:0] w;
         sample_type s;
         begin
            case (phase)
               HUNT: if (b == SyncFirst) phase = SYNC2;
               SYNC2: begin
                  if (b == SyncSecond) begin
                     phase = HEADER; byte_cnt = 0; resid = 0;
                  end else phase = HUNT;
               end
               HEADER: begin
                  if (!byte_cnt[0]) begin
                     low_hold = b; byte_cnt++;
                  end else begin
                     w = {b, low_hold};
                     resid ^= w;
                     if (byte_cnt == 1) count = b;
                     else if (byte_cnt == 3) first_ang = w >> 1;
                     else if (byte_cnt == 5) last_ang = w >> 1;
                     if (byte_cnt >= 7) begin
                        if (first_ang > last_ang)
                           span = longint'(last_ang) + 23040 - longint'(first_ang);
                        else span = longint'(last_ang) - longint'(first_ang);
                        byte_cnt = 0; cur = 0;
                        phase = (count == 0) ? HUNT : DATA;
                     end else byte_cnt++;
                  end
               end
               default: begin
                  if (byte_cnt == 0) begin
                     low_hold = b; byte_cnt = 1;
                  end else begin
                     byte_cnt = 0;
                     w = {b, low_hold};
                     resid ^= w;
                     s.distance = w;
                     s.angle = angle_of(longint'(w), longint'(cur));
                     s.sample_index = cur;
                     s.last_sample = (int'(cur) + 1 >= int'(count));
                     s.check_residual = resid;
                     pending.push_back(s);
                     cur++;
                     if (cur >= count) begin
                        phase = HUNT; cur = 0;
                     end
                  end
               end
            endcase
         end
      endfunction

      task check_sample(sample_type got);
         sample_type e;
         begin
            if (pending.size() == 0) begin
               report("unexpected word", got.distance, 0);
               return;
            end
            e = pending.pop_front();
            matched++;
            if (got.distance !== e.distance) report("distance", got.distance, e.distance);
            if (got.angle !== e.angle) report("angle", got.angle, e.angle);
            if (got.sample_index !== e.sample_index)
               report("sample_index", got.sample_index, e.sample_index);
            if (got.last_sample !== e.last_sample)
               report("last_sample", got.last_sample, e.last_sample);
            if (got.check_residual !== e.check_residual)
               report("check_residual", got.check_residual, e.check_residual);
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0] req_rx_byte = 0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic [15:0] rsp_distance, rsp_angle, rsp_check_residual;
   logic [7:0] rsp_sample_index;
   logic rsp_last_sample;

   sample_board board = new();
   int sent = 0;
   int hold_off = 0;
   bit no_idle = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   lidar_scan_packet_decoder i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_distance(rsp_distance),
      .rsp_angle(rsp_angle), .rsp_sample_index(rsp_sample_index),
      .rsp_last_sample(rsp_last_sample), .rsp_check_residual(rsp_check_residual)
   );

   // send one byte, with a random gap unless idling is off; valid stays up after
   task automatic send_byte(input logic [7:0] b);
      int gap;
      begin
         gap = no_idle ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0);
         @(negedge clock);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1;
         req_rx_byte <= b;
         do @(posedge clock); while (req_stall);
         board.note_byte(b);
         sent++;
      end
   endtask

   task automatic send_word(input logic [15:0] w);
      begin
         send_byte(w[7:0]);
         send_byte(w[15:8]);
      end
   endtask

   // whole packet: header then distances drawn per mode
   task automatic send_packet(input logic [7:0] n, input logic [15:0] a0,
                              input logic [15:0] a1, input int mode);
      logic [15:0] d;
      begin
         send_byte(SyncFirst);
         send_byte(SyncSecond);
         send_word({n, 8'($urandom)});
         send_word(a0);
         send_word(a1);
         send_word(16'($urandom));
         for (int i = 0; i < n; i++) begin
            case (mode)
               0: d = 16'($urandom_range(0, 1200));
               1: d = 16'($urandom);
               default: d = (i % 3 == 0) ? 16'd0 : ((i % 3 == 1) ? 16'hFFFF : 16'd1);
            endcase
            send_word(d);
         end
      end
   endtask

   // drop valid and wait for every expected word
   task automatic wait_drained();
      begin
         @(negedge clock);
         req_valid <= 0;
         while (board.pending.size() != 0) @(negedge clock);
         repeat (60) @(negedge clock);
      end
   endtask

   // result side: random stall, with an optional long hold-off
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else if (no_idle) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 17) < $urandom_range(0, 17));
   end

   always @(posedge clock) begin
      sample_type r;
      if (!reset && rsp_valid && !rsp_stall) begin
         r.distance = rsp_distance;
         r.angle = rsp_angle;
         r.sample_index = rsp_sample_index;
         r.last_sample = rsp_last_sample;
         r.check_residual = rsp_check_residual;
         board.check_sample(r);
      end
   end

   initial begin
      #20000000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: bad sync, including a repeated first sync byte
      send_byte(8'h00); send_byte(SyncFirst); send_byte(SyncFirst);
      send_byte(8'h55);
      // zero count, then single sample, then wrap cases and edge distances
      send_packet(8'd0, 16'd100, 16'd200, 0);
      send_packet(8'd1, 16'd46078, 16'd10, 2);
      send_packet(8'd3, 16'hFFFF, 16'd0, 2);
      send_packet(8'd2, 16'd0, 16'hFFFF, 1);
      wait_drained();
      // long receiver hold-off while bytes keep coming
      hold_off = 400;
      send_packet(8'd12, 16'($urandom), 16'($urandom), 0);
      wait_drained();
      // random part, mostly packets, some noise
      while (sent < 1250) begin
         no_idle = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end else if ($urandom_range(0, 19) == 0) begin
            send_packet(8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom), 1);
         end else begin
            send_packet(8'($urandom_range(0, 8)), 16'($urandom), 16'($urandom),
                        $urandom_range(0, 2));
         end
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      no_idle = 0;
      wait_drained();
      $display("sent %0d bytes, checked %0d samples across sync faults and packet shapes",
               sent, board.matched);
      if (err_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

/* files.f */
src/lspd_pkg.sv
src/lspd_datapath.sv
src/lspd_control.sv
src/lidar_scan_packet_decoder.sv
tb/tb_top.sv
